### hw/rtl/fkr_pkg.sv
// Shared types and constants for the keyed-removal queue.
package fkr_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_KEY_BITS    = 16;
  localparam int DEF_TAG_BITS    = 8;

  localparam int CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_SOLD_OUT  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic remove;
  } cell_ctl_t;

endpackage

### hw/rtl/fkr_cell.sv
// One queue slot: holds a key and tag, matches, and shifts from its neighbor.
module fkr_cell #(
  parameter int KEY_BITS = fkr_pkg::DEF_KEY_BITS,
  parameter int TAG_BITS = fkr_pkg::DEF_TAG_BITS
) (
  input  logic                clk,
  input  fkr_pkg::cell_ctl_t  ctl,
  input  logic                occupied,
  input  logic                tail,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [TAG_BITS-1:0] new_tag,
  input  logic [KEY_BITS-1:0] nbr_key,
  input  logic [TAG_BITS-1:0] nbr_tag,
  input  logic                hit_in,
  input  logic [TAG_BITS-1:0] found_tag_in,
  output logic                hit_out,
  output logic [TAG_BITS-1:0] found_tag_out,
  output logic [KEY_BITS-1:0] key,
  output logic [TAG_BITS-1:0] tag
);
  import fkr_pkg::*;

  logic match;
  logic first;

  assign match         = occupied && (key == new_key);
  assign first         = match && !hit_in;
  assign hit_out       = hit_in || match;
  assign found_tag_out = found_tag_in | (first ? tag : '0);

  always_ff @(posedge clk) begin
    priority if (ctl.push && tail) begin
      key <= new_key;
      tag <= new_tag;
    end else if (ctl.pop || (ctl.remove && hit_out)) begin
      key <= nbr_key;
      tag <= nbr_tag;
    end else begin
      key <= key;
      tag <= tag;
    end
  end

endmodule

### hw/rtl/fifo_with_keyed_removal_unit.sv
// Top level: ordered queue with admission counter and removal by key.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  input    | in_valid / in_stall  | opcode, person_key, movie_tag
//  output   | out_valid / out_stall| status, out_key, out_movie, queue_length,
//           |                      | tickets_left
//  config   | APB psel/penable     | ticket_capacity at byte address 0
//
// One transaction per cycle while in_stall is low; each is resolved in the cycle it is
// accepted by the row of slot cells (parallel key compare, first-match chain, shift toward
// the head). The result appears in an output register in the following cycle.
// Reset clears the length, the admitted count and the output valid; capacity resets to 64.
// in_stall rises only while a result is held and out_stall is high.
module fifo_with_keyed_removal_unit #(
  parameter int QUEUE_DEPTH = fkr_pkg::DEF_QUEUE_DEPTH,
  parameter int KEY_BITS    = fkr_pkg::DEF_KEY_BITS,
  parameter int TAG_BITS    = fkr_pkg::DEF_TAG_BITS,
  localparam int LEN_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   opcode,
  input  logic [KEY_BITS-1:0]          person_key,
  input  logic [TAG_BITS-1:0]          movie_tag,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic [KEY_BITS-1:0]          out_key,
  output logic [TAG_BITS-1:0]          out_movie,
  output logic [LEN_W-1:0]             queue_length,
  output logic [fkr_pkg::CAP_W-1:0]    tickets_left,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fkr_pkg::PADDR_W-1:0]  paddr,
  input  logic [fkr_pkg::PDATA_W-1:0]  pwdata,
  output logic [fkr_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import fkr_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic [LEN_W-1:0] count;
  logic [LEN_W-1:0] count_next;
  logic [CAP_W-1:0] admitted;
  logic [CAP_W-1:0] admitted_next;

  logic                accept;
  op_t                 op;
  cell_ctl_t           ctl;
  logic                push_ok;
  logic                empty;
  logic                found;
  status_t             res_status;
  logic [KEY_BITS-1:0] res_key;
  logic [TAG_BITS-1:0] res_tag;
  logic [CAP_W-1:0]    res_left;

  logic [KEY_BITS-1:0] cell_key [QUEUE_DEPTH];
  logic [TAG_BITS-1:0] cell_tag [QUEUE_DEPTH];
  logic                hit      [QUEUE_DEPTH+1];
  logic [TAG_BITS-1:0] ftag     [QUEUE_DEPTH+1];

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1] == REG_CAPACITY) ? PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign op       = op_t'(opcode);
  assign empty    = (count == '0);
  assign push_ok  = (admitted < capacity) && (count != LEN_W'(QUEUE_DEPTH));
  assign found    = hit[QUEUE_DEPTH];

  assign ctl.push   = accept && op == OP_PUSH && push_ok;
  assign ctl.pop    = accept && op == OP_POP && !empty;
  assign ctl.remove = accept && op == OP_REMOVE;

  assign hit[0]  = 1'b0;
  assign ftag[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam int NBR = (i + 1 < QUEUE_DEPTH) ? i + 1 : i;
    fkr_cell #(
      .KEY_BITS (KEY_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk           (clk),
      .ctl           (ctl),
      .occupied      (count > LEN_W'(i)),
      .tail          (count == LEN_W'(i)),
      .new_key       (person_key),
      .new_tag       (movie_tag),
      .nbr_key       (cell_key[NBR]),
      .nbr_tag       (cell_tag[NBR]),
      .hit_in        (hit[i]),
      .found_tag_in  (ftag[i]),
      .hit_out       (hit[i+1]),
      .found_tag_out (ftag[i+1]),
      .key           (cell_key[i]),
      .tag           (cell_tag[i])
    );
  end

  always_comb begin
    count_next    = count;
    admitted_next = admitted;
    res_status    = ST_DONE;
    res_key       = '0;
    res_tag       = '0;
    unique case (op)
      OP_PUSH: begin
        if (push_ok) begin
          count_next    = count + LEN_W'(1);
          admitted_next = admitted + CAP_W'(1);
        end else begin
          res_status = ST_SOLD_OUT;
        end
      end
      OP_POP: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_key    = cell_key[0];
          res_tag    = cell_tag[0];
          count_next = count - LEN_W'(1);
        end
      end
      OP_REMOVE: begin
        priority if (empty) begin
          res_status = ST_EMPTY;
        end else if (found) begin
          res_key    = person_key;
          res_tag    = ftag[QUEUE_DEPTH];
          count_next = count - LEN_W'(1);
          if (admitted != '0) begin
            admitted_next = admitted - CAP_W'(1);
          end
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        count_next    = '0;
        admitted_next = '0;
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
    res_left = (capacity > admitted_next) ? capacity - admitted_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      admitted  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        admitted  <= admitted_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= res_status;
      out_key      <= res_key;
      out_movie    <= res_tag;
      queue_length <= count_next;
      tickets_left <= res_left;
    end
  end

endmodule
